// ===== hw/rtl/ffm_pkg.sv =====
// Package with the shared types and constants of the follow feed merge engine.
`default_nettype none
package ffm_pkg;
	localparam int USERS_DEF = 16;
	localparam int LOG_DEPTH_DEF = 16;
	localparam int USER_W = 4;
	localparam int TWEET_W = 16;
	localparam int TIME_W = 32;
	localparam int LIMIT_W = 5;
	localparam int MAX_FEED = 16;
	localparam logic [LIMIT_W-1:0] FEED_LIMIT_RESET = 5'd10;
	localparam logic [TIME_W-1:0] CLOCK_MAX = 32'hFFFF_FFFF;

	localparam logic [1:0] REQ_POST = 2'd0;
	localparam logic [1:0] REQ_FOLLOW = 2'd1;
	localparam logic [1:0] REQ_UNFOLLOW = 2'd2;
	localparam logic [1:0] REQ_FEED = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_SELF = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	localparam logic [0:0] REG_FEED_LIMIT = 1'd0;

	typedef struct packed {
		logic [1:0] req_type;
		logic [USER_W-1:0] user;
		logic [USER_W-1:0] other_user;
		logic [TWEET_W-1:0] tweet_in;
	} req_t;

	typedef struct packed {
		logic [TWEET_W-1:0] tweet_out;
		logic entry_valid;
		logic last;
		logic [1:0] status;
	} rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ffm_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module ffm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/follow_feed_merge_engine.sv =====
// Top level of the follow feed merge engine: tables, sequencer and shared compare unit.
//
// Requests enter on req (valid/ready) and results leave on rsp (valid/ready).
// Post, follow and unfollow give one result with last set; a feed gives one
// result per tweet id, newest first, with last on the final one, or a single
// empty result when nothing is found or feed_limit is zero. feed_limit is
// written over the APB port. One request is handled at a time; ready is low
// until its final result has been taken. A feed scans every author once per
// emitted entry through one shared log RAM port and one time comparator. A
// stalled receiver holds the sequencer in place. Reset clears the follow
// matrix, the per-user counters, the clock and sets feed_limit to 10; log
// contents stay undefined and are only read below each user's count.
`default_nettype none
module follow_feed_merge_engine #(
	parameter int USERS = ffm_pkg::USERS_DEF,
	parameter int LOG_DEPTH = ffm_pkg::LOG_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire ffm_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output ffm_pkg::rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int AW = UW + LW;
	localparam int EW = ffm_pkg::TIME_W + ffm_pkg::TWEET_W;
	localparam int FW = $clog2(ffm_pkg::MAX_FEED + 1);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_WAIT, S_CMP, S_EMIT, S_OUT} state_t;
	state_t state_q;

	logic [ffm_pkg::LIMIT_W-1:0] feed_limit_q;
	logic [USERS-1:0] follow_q [USERS];
	logic [CW-1:0] count_q [USERS];
	logic [LW-1:0] head_q [USERS];
	logic [CW-1:0] taken_q [USERS];
	logic [ffm_pkg::TIME_W-1:0] time_q;
	ffm_pkg::req_t req_q;
	logic [UW:0] scan_q;
	logic found_q;
	logic [UW-1:0] best_q;
	logic [ffm_pkg::TIME_W-1:0] best_time_q;
	logic [ffm_pkg::TWEET_W-1:0] best_id_q;
	logic [FW-1:0] emitted_q;
	logic [FW-1:0] limit_q;
	logic [AW:0] avail_q;
	ffm_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	ffm_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_log (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic [UW-1:0] su;
	logic [UW-1:0] ru, rv;
	logic u_ok, v_ok;
	logic scan_member, scan_avail;
	logic [LW-1:0] slot;
	logic [LW:0] slot_sum;
	logic [ffm_pkg::TIME_W-1:0] rd_time;
	logic [1:0] op_status;
	logic [FW-1:0] cap_limit;

	assign su = scan_q[UW-1:0];
	assign ru = req_q.user[UW-1:0];
	assign rv = req_q.other_user[UW-1:0];
	assign u_ok = ({{(UW+4){1'b0}}, req_q.user} < (UW+8)'(USERS));
	assign v_ok = ({{(UW+4){1'b0}}, req_q.other_user} < (UW+8)'(USERS));
	assign scan_member = (su == ru) || follow_q[ru][su];
	assign scan_avail = scan_member && (taken_q[su] < count_q[su]);
	// Newest unread entry of the scanned author sits taken+1 entries behind the head.
	always_comb begin
		slot_sum = {1'b0, head_q[su]} + (LW+1)'(LOG_DEPTH) - 1'b1 - (LW+1)'(taken_q[su]);
		if (slot_sum >= (LW+1)'(LOG_DEPTH)) begin
			slot_sum = slot_sum - (LW+1)'(LOG_DEPTH);
		end
		slot = slot_sum[LW-1:0];
	end
	assign rd_time = ram_rdata[EW-1 -: ffm_pkg::TIME_W];

	always_comb begin
		op_status = ffm_pkg::ST_DONE;
		if (u_ok && req_q.req_type == ffm_pkg::REQ_POST && time_q == ffm_pkg::CLOCK_MAX) begin
			op_status = ffm_pkg::ST_REFUSED;
		end else if (u_ok && v_ok && req_q.req_type == ffm_pkg::REQ_FOLLOW && ru == rv) begin
			op_status = ffm_pkg::ST_SELF;
		end
	end

	always_comb begin
		if (feed_limit_q > ffm_pkg::LIMIT_W'(ffm_pkg::MAX_FEED)) begin
			cap_limit = FW'(ffm_pkg::MAX_FEED);
		end else begin
			cap_limit = FW'(feed_limit_q);
		end
		if (LOG_DEPTH < ffm_pkg::MAX_FEED &&
			feed_limit_q > ffm_pkg::LIMIT_W'(LOG_DEPTH)) begin
			cap_limit = FW'(LOG_DEPTH);
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = {su, slot};
		ram_wdata = {time_q + 1'b1, req_q.tweet_in};
		if (state_q == S_READ && req_q.req_type == ffm_pkg::REQ_POST) begin
			ram_addr = {ru, head_q[ru]};
			ram_we = u_ok && (time_q != ffm_pkg::CLOCK_MAX);
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign pready = 1'b1;
	assign prdata = (paddr == {ffm_pkg::REG_FEED_LIMIT, 1'b0})
		? {{(32-ffm_pkg::LIMIT_W){1'b0}}, feed_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_limit_q <= ffm_pkg::FEED_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr == {ffm_pkg::REG_FEED_LIMIT, 1'b0}) begin
			feed_limit_q <= pwdata[ffm_pkg::LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			time_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_time_q <= '0;
			best_id_q <= '0;
			emitted_q <= '0;
			limit_q <= '0;
			avail_q <= '0;
			for (int i = 0; i < USERS; i++) begin
				follow_q[i] <= '0;
				count_q[i] <= '0;
				head_q[i] <= '0;
				taken_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_READ;
						for (int i = 0; i < USERS; i++) taken_q[i] <= '0;
						emitted_q <= '0;
						scan_q <= '0;
						found_q <= 1'b0;
						avail_q <= '0;
						limit_q <= cap_limit;
					end
				end
				S_READ: begin
					rsp_q <= '{tweet_out: '0, entry_valid: 1'b0, last: 1'b1,
						status: op_status};
					if (!u_ok) begin
						state_q <= S_OUT;
						rsp_valid_q <= 1'b1;
					end else if (req_q.req_type == ffm_pkg::REQ_FEED) begin
						if (emitted_q >= limit_q) begin
							state_q <= S_OUT;
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= S_WAIT;
						end
					end else begin
						state_q <= S_OUT;
						rsp_valid_q <= 1'b1;
						if (req_q.req_type == ffm_pkg::REQ_POST) begin
							if (time_q != ffm_pkg::CLOCK_MAX) begin
								time_q <= time_q + 1'b1;
								head_q[ru] <= (LOG_DEPTH > 1 &&
									{1'b0, head_q[ru]} != (LW+1)'(LOG_DEPTH - 1))
									? head_q[ru] + 1'b1 : '0;
								if (count_q[ru] != CW'(LOG_DEPTH)) begin
									count_q[ru] <= count_q[ru] + 1'b1;
								end
							end
						end else if (v_ok) begin
							if (req_q.req_type == ffm_pkg::REQ_FOLLOW) begin
								if (ru != rv) follow_q[ru][rv] <= 1'b1;
							end else begin
								follow_q[ru][rv] <= 1'b0;
							end
						end
					end
				end
				S_WAIT: state_q <= S_CMP;
				S_CMP: begin
					// One author per pass through the shared comparator.
					if (scan_avail && (!found_q || rd_time > best_time_q)) begin
						found_q <= 1'b1;
						best_q <= su;
						best_time_q <= rd_time;
						best_id_q <= ram_rdata[ffm_pkg::TWEET_W-1:0];
					end
					// Entries still unread across all merged authors decide the last one.
					if (scan_avail) begin
						avail_q <= avail_q + (AW+1)'(count_q[su] - taken_q[su]);
					end
					if (scan_q == (UW+1)'(USERS - 1)) begin
						state_q <= S_EMIT;
					end else begin
						scan_q <= scan_q + 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_EMIT: begin
					scan_q <= '0;
					found_q <= 1'b0;
					avail_q <= '0;
					if (found_q) begin
						taken_q[best_q] <= taken_q[best_q] + 1'b1;
						emitted_q <= emitted_q + 1'b1;
						rsp_q <= '{tweet_out: best_id_q, entry_valid: 1'b1,
							last: (emitted_q + 1'b1 == limit_q) || (avail_q == (AW+1)'(1)),
							status: ffm_pkg::ST_DONE};
						rsp_valid_q <= 1'b1;
						state_q <= S_OUT;
					end else if (emitted_q == '0) begin
						rsp_q <= '{tweet_out: '0, entry_valid: 1'b0, last: 1'b1,
							status: ffm_pkg::ST_DONE};
						rsp_valid_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						// Nothing more to merge: the request ended on the prior entry.
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
						if (rsp_q.last) state_q <= S_IDLE;
						else state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the follow feed merge engine, with its own feed predictor.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUSERS = 16;
	localparam int DEPTH = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ffm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ffm_pkg::rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Predictor state: follow bits, per-author ring logs, global clock and feed limit.
	logic [NUSERS-1:0] follows [NUSERS];
	logic [31:0] log_stamp [NUSERS][DEPTH];
	logic [15:0] log_tweet [NUSERS][DEPTH];
	int log_fill [NUSERS];
	int log_next [NUSERS];
	logic [31:0] clock_now;
	logic [4:0] feed_cap;

	ffm_pkg::rsp_t pending_rsp [$];
	int mismatches = 0;
	longint cycles = 0;
	bit steady_send = 1'b0;
	bit steady_take = 1'b0;

	follow_feed_merge_engine dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 0;
		end else if (r < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic ffm_pkg::rsp_t make_rsp(logic [15:0] id, logic ev, logic lst,
			logic [1:0] st);
		ffm_pkg::rsp_t r;
		r.tweet_out = id;
		r.entry_valid = ev;
		r.last = lst;
		r.status = st;
		return r;
	endfunction

	task automatic queue_rsp(input ffm_pkg::rsp_t r);
		pending_rsp = {pending_rsp, r};
	endtask

	// Merge the logs of the owner and its followees on time, newest first.
	task automatic predict_feed(input int owner);
		int taken [NUSERS];
		int cap;
		int n;
		int best;
		int slot;
		logic [31:0] best_stamp;
		ffm_pkg::rsp_t r;
		cap = feed_cap > 16 ? 16 : int'(feed_cap);
		n = 0;
		foreach (taken[a]) taken[a] = 0;
		while (n < cap) begin
			best = -1;
			best_stamp = '0;
			for (int a = 0; a < NUSERS; a++) begin
				if ((a == owner || follows[owner][a]) && taken[a] < log_fill[a]) begin
					slot = (log_next[a] + DEPTH - 1 - taken[a]) % DEPTH;
					if (best < 0 || log_stamp[a][slot] > best_stamp) begin
						best = a;
						best_stamp = log_stamp[a][slot];
					end
				end
			end
			if (best < 0) break;
			slot = (log_next[best] + DEPTH - 1 - taken[best]) % DEPTH;
			r = make_rsp(log_tweet[best][slot], 1'b1, 1'b0, ffm_pkg::ST_DONE);
			queue_rsp(r);
			taken[best]++;
			n++;
		end
		if (n == 0) begin
			queue_rsp(make_rsp('0, 1'b0, 1'b1, ffm_pkg::ST_DONE));
		end else begin
			r = pending_rsp.pop_back();
			r.last = 1'b1;
			queue_rsp(r);
		end
	endtask

	task automatic predict_request(input ffm_pkg::req_t q);
		logic [1:0] st;
		int u;
		int v;
		u = int'(q.user);
		v = int'(q.other_user);
		st = ffm_pkg::ST_DONE;
		case (q.req_type)
			ffm_pkg::REQ_FEED: begin
				predict_feed(u);
				return;
			end
			ffm_pkg::REQ_POST: begin
				if (clock_now == ffm_pkg::CLOCK_MAX) begin
					st = ffm_pkg::ST_REFUSED;
				end else begin
					clock_now = clock_now + 1;
					log_stamp[u][log_next[u]] = clock_now;
					log_tweet[u][log_next[u]] = q.tweet_in;
					log_next[u] = (log_next[u] + 1) % DEPTH;
					if (log_fill[u] < DEPTH) log_fill[u]++;
				end
			end
			ffm_pkg::REQ_FOLLOW: begin
				if (u == v) st = ffm_pkg::ST_SELF;
				else follows[u][v] = 1'b1;
			end
			default: begin
				follows[u][v] = 1'b0;
			end
		endcase
		queue_rsp(make_rsp('0, 1'b0, 1'b1, st));
	endtask

	// Valid stays high across back-to-back requests; it only drops for a gap.
	task automatic send_req(input ffm_pkg::req_t q);
		int gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		do @(posedge clk); while (!req_ready);
		predict_request(q);
	endtask

	task automatic send_fields(input logic [1:0] kind, input int u, input int v,
			input logic [15:0] id);
		ffm_pkg::req_t q;
		q.req_type = kind;
		q.user = 4'(u);
		q.other_user = 4'(v);
		q.tweet_in = id;
		send_req(q);
	endtask

	// Register writes happen only with the engine idle.
	task automatic write_feed_limit(input logic [31:0] value);
		@(posedge clk);
		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (5) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ffm_pkg::REG_FEED_LIMIT, 1'b0};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		feed_cap = value[4:0];
	endtask

	always @(posedge clk) begin
		ffm_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.tweet_out !== want.tweet_out || rsp.entry_valid !== want.entry_valid
						|| rsp.last !== want.last || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch: expected %p, got %p", want, rsp);
					end
				end
			end
		end
		if (steady_take) rsp_ready <= 1'b1;
		else if ($urandom_range(0, 9) < 7) rsp_ready <= 1'b1;
		else rsp_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
	end

	task automatic test_basic_requests();
		send_fields(ffm_pkg::REQ_FEED, 0, 0, 16'h0000);
		send_fields(ffm_pkg::REQ_POST, 0, 5, 16'h0000);
		send_fields(ffm_pkg::REQ_POST, 15, 0, 16'hFFFF);
		send_fields(ffm_pkg::REQ_POST, 1, 15, 16'hA5A5);
		send_fields(ffm_pkg::REQ_FOLLOW, 3, 3, 16'h1234);
		send_fields(ffm_pkg::REQ_UNFOLLOW, 3, 3, 16'h0000);
		send_fields(ffm_pkg::REQ_FOLLOW, 0, 15, 16'h5A5A);
		send_fields(ffm_pkg::REQ_FOLLOW, 0, 1, 16'h0000);
		send_fields(ffm_pkg::REQ_FEED, 0, 7, 16'hFFFF);
		send_fields(ffm_pkg::REQ_FOLLOW, 15, 0, 16'h0000);
		send_fields(ffm_pkg::REQ_FEED, 15, 0, 16'h0000);
		send_fields(ffm_pkg::REQ_UNFOLLOW, 0, 15, 16'h0000);
		send_fields(ffm_pkg::REQ_FEED, 0, 0, 16'h0000);
		send_fields(ffm_pkg::REQ_FEED, 9, 0, 16'h0000);
	endtask

	// Overfill one log so the ring wraps, then read it at several limits.
	task automatic test_feed_limits();
		for (int i = 0; i < 20; i++) begin
			send_fields(ffm_pkg::REQ_POST, 4, i, 16'(16'h0100 + i));
		end
		send_fields(ffm_pkg::REQ_FOLLOW, 2, 4, 16'h0000);
		write_feed_limit(32'd16);
		send_fields(ffm_pkg::REQ_FEED, 2, 0, 16'h0000);
		write_feed_limit(32'd1);
		send_fields(ffm_pkg::REQ_FEED, 4, 0, 16'h0000);
		write_feed_limit(32'd0);
		send_fields(ffm_pkg::REQ_FEED, 4, 0, 16'h0000);
		write_feed_limit(32'd31);
		send_fields(ffm_pkg::REQ_FEED, 2, 0, 16'h0000);
		write_feed_limit(32'hFFFF_FFF1);
		send_fields(ffm_pkg::REQ_FEED, 4, 0, 16'h0000);
	endtask

	task automatic test_random_traffic();
		ffm_pkg::req_t q;
		int r;
		for (int i = 0; i < 60; i++) begin
			if (i % 30 == 0) begin
				steady_send = (i == 30);
				steady_take = (i == 30);
				write_feed_limit($urandom_range(0, 31));
			end
			q.user = 4'($urandom_range(0, 15));
			q.other_user = 4'($urandom_range(0, 15));
			q.tweet_in = 16'($urandom);
			r = $urandom_range(0, 9);
			if (r < 4) q.req_type = ffm_pkg::REQ_POST;
			else if (r < 6) q.req_type = ffm_pkg::REQ_FOLLOW;
			else if (r < 7) q.req_type = ffm_pkg::REQ_UNFOLLOW;
			else q.req_type = ffm_pkg::REQ_FEED;
			send_req(q);
		end
		steady_send = 1'b0;
		steady_take = 1'b0;
	endtask

	initial begin
		foreach (follows[u]) begin
			follows[u] = '0;
			log_fill[u] = 0;
			log_next[u] = 0;
		end
		clock_now = '0;
		feed_cap = ffm_pkg::FEED_LIMIT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_feed_limits();
		test_random_traffic();
		@(posedge clk);
		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
